FILE: rtl/hrkd_pkg.sv
// ----------------------------------------------------------------------------
// hrkd_pkg
// Types, key codes and the usage-code map for the keyboard report diff block.
// ----------------------------------------------------------------------------
package hrkd_pkg;

  localparam int unsigned NUM_INPUT_SLOTS = 6;
  localparam int unsigned NUM_MOD_EVENTS  = 6;

  localparam logic [7:0] CODE_CTRL  = 8'h9D;
  localparam logic [7:0] CODE_SHIFT = 8'hB6;
  localparam logic [7:0] CODE_ALT   = 8'hB8;
  localparam logic [7:0] CODE_NONE  = 8'h00;

  // modifier events in output order: lctrl, lshift, lalt, rctrl, rshift, ralt
  localparam logic [NUM_MOD_EVENTS-1:0][2:0] MOD_POS = {
    3'd6, 3'd5, 3'd4, 3'd2, 3'd1, 3'd0
  };
  localparam logic [NUM_MOD_EVENTS-1:0][7:0] MOD_CODE = {
    CODE_ALT, CODE_SHIFT, CODE_CTRL, CODE_ALT, CODE_SHIFT, CODE_CTRL
  };

  typedef struct packed {
    logic       press;
    logic [7:0] code;
  } hrkd_event_t;

  function automatic logic [7:0] map_usage(input logic [7:0] u);
    logic [7:0] k;
    k = CODE_NONE;
    if (u >= 8'h04 && u <= 8'h1D) begin
      k = u + 8'h5D;
    end else if (u >= 8'h1E && u <= 8'h26) begin
      k = u + 8'h13;
    end else begin
      case (u)
        8'h27: k = 8'h30;
        8'h28: k = 8'd13;
        8'h29: k = 8'd27;
        8'h2A: k = 8'd127;
        8'h2B: k = 8'd9;
        8'h2C: k = 8'd32;
        8'h4F: k = 8'hAE;
        8'h50: k = 8'hAC;
        8'h51: k = 8'hAF;
        8'h52: k = 8'hAD;
        8'hE0, 8'hE4: k = CODE_CTRL;
        8'hE1, 8'hE5: k = CODE_SHIFT;
        8'hE2, 8'hE6: k = CODE_ALT;
        default: k = CODE_NONE;
      endcase
    end
    return k;
  endfunction

endpackage

FILE: rtl/hrkd_diff.sv
// ----------------------------------------------------------------------------
// hrkd_diff
// Compares a report with the previous one and builds the ordered list of
// candidate events with their valid flags.
// ----------------------------------------------------------------------------
module hrkd_diff #(
  parameter int unsigned KEY_SLOTS = 6,
  parameter int unsigned NUM_EV    = 6 + 2 * KEY_SLOTS
) (
  input  logic [7:0]                          mods_i,
  input  logic [KEY_SLOTS-1:0][7:0]           keys_i,
  input  logic [7:0]                          prior_mods_i,
  input  logic [KEY_SLOTS-1:0][7:0]           prior_keys_i,
  output logic [NUM_EV-1:0]                   ev_valid_o,
  output hrkd_pkg::hrkd_event_t [NUM_EV-1:0]  events_o
);
  import hrkd_pkg::*;

  logic [7:0]           changed;
  logic [KEY_SLOTS-1:0] new_held;
  logic [KEY_SLOTS-1:0] old_held;
  logic [KEY_SLOTS-1:0][7:0] new_map;
  logic [KEY_SLOTS-1:0][7:0] old_map;

  assign changed = mods_i ^ prior_mods_i;

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      new_held[i] = 1'b0;
      old_held[i] = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (prior_keys_i[j] == keys_i[i]) new_held[i] = 1'b1;
        if (keys_i[j] == prior_keys_i[i]) old_held[i] = 1'b1;
      end
      new_map[i] = map_usage(keys_i[i]);
      old_map[i] = map_usage(prior_keys_i[i]);
    end
  end

  always_comb begin
    for (int m = 0; m < NUM_MOD_EVENTS; m++) begin
      ev_valid_o[m]     = changed[MOD_POS[m]];
      events_o[m].press = mods_i[MOD_POS[m]];
      events_o[m].code  = MOD_CODE[m];
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      ev_valid_o[NUM_MOD_EVENTS + i] = (keys_i[i] != 8'h00) && !new_held[i] &&
                                       (new_map[i] != CODE_NONE);
      events_o[NUM_MOD_EVENTS + i].press = 1'b1;
      events_o[NUM_MOD_EVENTS + i].code  = new_map[i];
      ev_valid_o[NUM_MOD_EVENTS + KEY_SLOTS + i] = (prior_keys_i[i] != 8'h00) &&
                                                   !old_held[i] &&
                                                   (old_map[i] != CODE_NONE);
      events_o[NUM_MOD_EVENTS + KEY_SLOTS + i].press = 1'b0;
      events_o[NUM_MOD_EVENTS + KEY_SLOTS + i].code  = old_map[i];
    end
  end

endmodule

FILE: rtl/hrkd_drain.sv
// ----------------------------------------------------------------------------
// hrkd_drain
// Event buffer: holds one report's pending events and hands out the lowest
// pending one per output word.
// ----------------------------------------------------------------------------
module hrkd_drain #(
  parameter int unsigned NUM_EV = 18
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic [NUM_EV-1:0]                   ev_valid_i,
  input  hrkd_pkg::hrkd_event_t [NUM_EV-1:0]  events_i,
  output logic                                free_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                is_press_o,
  output logic [7:0]                          game_key_o,
  output logic                                last_event_o
);
  import hrkd_pkg::*;

  logic [NUM_EV-1:0]        pend_q, pend_d;
  hrkd_event_t [NUM_EV-1:0] events_q;
  logic [NUM_EV-1:0]        sel;
  logic [NUM_EV-1:0]        rest;
  logic                     fire;

  assign sel          = pend_q & (~pend_q + NUM_EV'(1));
  assign rest         = pend_q & ~sel;
  assign out_valid_o  = |pend_q;
  assign last_event_o = (rest == '0);
  assign fire         = out_valid_o && out_ready_i;
  assign free_o       = !out_valid_o || (fire && last_event_o);

  always_comb begin
    is_press_o = 1'b0;
    game_key_o = 8'h00;
    for (int k = 0; k < NUM_EV; k++) begin
      if (sel[k]) begin
        is_press_o = is_press_o | events_q[k].press;
        game_key_o = game_key_o | events_q[k].code;
      end
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (load_i) begin
      pend_d = ev_valid_i;
    end else if (fire) begin
      pend_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      events_q <= events_i;
    end
  end

endmodule

FILE: rtl/hid_report_key_event_diff.sv
// ----------------------------------------------------------------------------
// hid_report_key_event_diff
// Keyboard boot report diff: emits modifier, press and release key events.
// Path: an accepted report is held in the input register, then loaded into the event buffer.
// Throughput: one event word per cycle while out_ready_i is high; a report yields
// up to 6 + 2 * KEY_SLOTS events, and the next report loads as its last word leaves.
// Reset: prior report cleared to no modifiers and no keys, buffers empty.
// ----------------------------------------------------------------------------
module hid_report_key_event_diff #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] modifier_bits_i,
  input  logic [7:0] key_slot_0_i,
  input  logic [7:0] key_slot_1_i,
  input  logic [7:0] key_slot_2_i,
  input  logic [7:0] key_slot_3_i,
  input  logic [7:0] key_slot_4_i,
  input  logic [7:0] key_slot_5_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_press_o,
  output logic [7:0] game_key_o,
  output logic       last_event_o
);
  import hrkd_pkg::*;

  localparam int unsigned NUM_EV = NUM_MOD_EVENTS + 2 * KEY_SLOTS;

  logic                              in_valid_q;
  logic [7:0]                        mods_q;
  logic [NUM_INPUT_SLOTS-1:0][7:0]   slots_q;
  logic [7:0]                        prior_mods_q;
  logic [KEY_SLOTS-1:0][7:0]         prior_keys_q;
  logic [KEY_SLOTS-1:0][7:0]         keys;
  logic [NUM_EV-1:0]                 ev_valid;
  hrkd_event_t [NUM_EV-1:0]          events;
  logic                              free;
  logic                              load;
  logic                              in_fire;

  assign load       = in_valid_q && free;
  assign in_ready_o = !in_valid_q || load;
  assign in_fire    = in_valid_i && in_ready_o;

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_keys
    if (i < NUM_INPUT_SLOTS) begin : g_in
      assign keys[i] = slots_q[i];
    end else begin : g_empty
      assign keys[i] = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      prior_mods_q <= '0;
      prior_keys_q <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (load) begin
        prior_mods_q <= mods_q;
        prior_keys_q <= keys;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mods_q  <= modifier_bits_i;
      slots_q <= {key_slot_5_i, key_slot_4_i, key_slot_3_i,
                  key_slot_2_i, key_slot_1_i, key_slot_0_i};
    end
  end

  hrkd_diff #(
    .KEY_SLOTS (KEY_SLOTS),
    .NUM_EV    (NUM_EV)
  ) u_diff (
    .mods_i       (mods_q),
    .keys_i       (keys),
    .prior_mods_i (prior_mods_q),
    .prior_keys_i (prior_keys_q),
    .ev_valid_o   (ev_valid),
    .events_o     (events)
  );

  hrkd_drain #(
    .NUM_EV (NUM_EV)
  ) u_drain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .ev_valid_i   (ev_valid),
    .events_i     (events),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_press_o   (is_press_o),
    .game_key_o   (game_key_o),
    .last_event_o (last_event_o)
  );

  a_more_after_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_event_o |=> out_valid_o)
    else $error("event buffer emptied before last word");

  a_empty_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_event_o && !load |=> !out_valid_o)
    else $error("word left pending after last word");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_mapped_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> game_key_o != CODE_NONE)
    else $error("unmapped key emitted");

endmodule

FILE: tb/key_event_checker.sv
// ----------------------------------------------------------------------------
// key_event_checker
// Watches both channels of the keyboard report diff block. Every accepted
// report is turned into the key event words it should produce. Every event
// word that leaves the block is checked against the oldest of those words.
// ----------------------------------------------------------------------------
module key_event_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        modifier_bits_i,
  input  logic [7:0]        key_slot_0_i,
  input  logic [7:0]        key_slot_1_i,
  input  logic [7:0]        key_slot_2_i,
  input  logic [7:0]        key_slot_3_i,
  input  logic [7:0]        key_slot_4_i,
  input  logic [7:0]        key_slot_5_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              is_press_i,
  input  logic [7:0]        game_key_i,
  input  logic              last_event_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  import hrkd_pkg::*;

  localparam int unsigned SLOTS        = 6;
  localparam int unsigned MAX_EVENTS   = 18;
  localparam int unsigned LGUI_BIT     = 3;
  localparam int unsigned RGUI_BIT     = 7;
  localparam int unsigned REPORTED_MAX = 10;

  typedef struct packed {
    logic       press;
    logic [7:0] code;
    logic       last;
  } key_event_t;

  key_event_t             expected_events[$];
  logic [7:0]             prior_mods;
  logic [SLOTS-1:0][7:0]  prior_keys;
  int unsigned            failures;

  function automatic logic [7:0] usage_to_key(input logic [7:0] usage);
    if (usage >= 8'h04 && usage <= 8'h1D) return 8'h61 + (usage - 8'h04);  // a..z
    if (usage >= 8'h1E && usage <= 8'h26) return 8'h31 + (usage - 8'h1E);  // 1..9
    case (usage)
      8'h27:        return 8'h30;
      8'h28:        return 8'd13;
      8'h29:        return 8'd27;
      8'h2A:        return 8'd127;
      8'h2B:        return 8'd9;
      8'h2C:        return 8'd32;
      8'h4F:        return 8'hAE;
      8'h50:        return 8'hAC;
      8'h51:        return 8'hAF;
      8'h52:        return 8'hAD;
      8'hE0, 8'hE4: return CODE_CTRL;
      8'hE1, 8'hE5: return CODE_SHIFT;
      8'hE2, 8'hE6: return CODE_ALT;
      default:      return CODE_NONE;
    endcase
  endfunction

  function automatic logic [7:0] modifier_key(input int unsigned bit_pos);
    case (bit_pos % 4)
      0:       return CODE_CTRL;
      1:       return CODE_SHIFT;
      default: return CODE_ALT;
    endcase
  endfunction

  function automatic logic held_in(input logic [SLOTS-1:0][7:0] keys,
                                   input logic [7:0] usage);
    for (int s = 0; s < SLOTS; s++) begin
      if (keys[s] == usage) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Events of one report in output order: modifiers, presses, releases.
  function automatic void predict_report(input logic [7:0] mods,
                                         input logic [SLOTS-1:0][7:0] keys);
    key_event_t  evs [MAX_EVENTS];
    int unsigned n;
    logic [7:0]  changed;
    logic [7:0]  key;
    n = 0;
    changed = mods ^ prior_mods;
    for (int b = 0; b < RGUI_BIT; b++) begin
      if (b != LGUI_BIT && changed[b]) begin
        evs[n].press = mods[b];
        evs[n].code  = modifier_key(b);
        evs[n].last  = 1'b0;
        n++;
      end
    end
    for (int s = 0; s < SLOTS; s++) begin
      key = usage_to_key(keys[s]);
      if (keys[s] != 8'h00 && !held_in(prior_keys, keys[s]) && key != CODE_NONE) begin
        evs[n].press = 1'b1;
        evs[n].code  = key;
        evs[n].last  = 1'b0;
        n++;
      end
    end
    for (int s = 0; s < SLOTS; s++) begin
      key = usage_to_key(prior_keys[s]);
      if (prior_keys[s] != 8'h00 && !held_in(keys, prior_keys[s]) && key != CODE_NONE) begin
        evs[n].press = 1'b0;
        evs[n].code  = key;
        evs[n].last  = 1'b0;
        n++;
      end
    end
    if (n > 0) evs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_events.push_back(evs[i]);
    prior_mods = mods;
    prior_keys = keys;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    key_event_t want;
    key_event_t seen;
    if (!rst_ni) begin
      expected_events.delete();
      prior_mods   = 8'h00;
      prior_keys   = '0;
      failures     = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen.press = is_press_i;
        seen.code  = game_key_i;
        seen.last  = last_event_i;
        if (expected_events.size() == 0) begin
          if (failures < REPORTED_MAX)
            $display("unexpected event word: press=%0b key=%02h last=%0b",
                     seen.press, seen.code, seen.last);
          failures++;
        end else begin
          want = expected_events.pop_front();
          if (seen !== want) begin
            if (failures < REPORTED_MAX)
              $display(
                "mismatch: exp press=%0b key=%02h last=%0b, got press=%0b key=%02h last=%0b",
                want.press, want.code, want.last, seen.press, seen.code, seen.last);
            failures++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        predict_report(modifier_bits_i, {key_slot_5_i, key_slot_4_i, key_slot_3_i,
                                         key_slot_2_i, key_slot_1_i, key_slot_0_i});
      fail_count_o <= failures;
      pending_o    <= expected_events.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives keyboard boot reports into the report diff block: a directed set
// for modifier, mapped, unmapped and repeated keys, then random key-roll
// sequences under four idle/stall mixes. The checker beside the block
// predicts and compares the event words; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned PHASE_ITEMS  = 60;
  localparam int unsigned TAIL_CYCLES  = 40;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_ready;
  logic [7:0]       modifier_bits = 8'h00;
  logic [5:0][7:0]  key_slots     = '0;
  logic             out_valid;
  logic             out_ready     = 1'b0;
  logic             is_press;
  logic [7:0]       game_key;
  logic             last_event;
  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      quiet_cycles  = 0;
  int unsigned      idle_pct      = 0;
  int unsigned      stall_pct     = 0;
  logic [7:0]       cur_mods      = 8'h00;
  logic [5:0][7:0]  cur_keys      = '0;

  hid_report_key_event_diff dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .modifier_bits_i (modifier_bits),
    .key_slot_0_i    (key_slots[0]),
    .key_slot_1_i    (key_slots[1]),
    .key_slot_2_i    (key_slots[2]),
    .key_slot_3_i    (key_slots[3]),
    .key_slot_4_i    (key_slots[4]),
    .key_slot_5_i    (key_slots[5]),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .is_press_o      (is_press),
    .game_key_o      (game_key),
    .last_event_o    (last_event)
  );

  key_event_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .modifier_bits_i (modifier_bits),
    .key_slot_0_i    (key_slots[0]),
    .key_slot_1_i    (key_slots[1]),
    .key_slot_2_i    (key_slots[2]),
    .key_slot_3_i    (key_slots[3]),
    .key_slot_4_i    (key_slots[4]),
    .key_slot_5_i    (key_slots[5]),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .is_press_i      (is_press),
    .game_key_i      (game_key),
    .last_event_i    (last_event),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // Leaves valid high after the accept; the next report replaces it, or an idle gap or a drain lowers it.
  task automatic send_report(input logic [7:0] mods, input logic [47:0] keys);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    modifier_bits <= mods;
    key_slots     <= keys;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic drain_events();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_usage();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 8'($urandom_range(8'h2C, 8'h04));
    if (r < 60) return 8'($urandom_range(8'h52, 8'h4F));
    if (r < 75) return 8'($urandom_range(8'hE7, 8'hE0));
    return 8'($urandom_range(255));
  endfunction

  // Mostly a realistic key roll from the previous report, some repeats and noise.
  task automatic run_phase(input int unsigned idle, input int unsigned stall);
    int unsigned choice;
    int unsigned r;
    logic [2:0]  mod_sel;
    logic [2:0]  slot_sel;
    idle_pct  = idle;
    stall_pct = stall;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      choice = $urandom_range(99);
      if (choice < 10) begin
        // unchanged report
      end else if (choice < 25) begin
        cur_mods = 8'($urandom);
        cur_keys = {16'($urandom), 32'($urandom)};
      end else begin
        if ($urandom_range(1)) begin
          mod_sel = 3'($urandom_range(7));
          cur_mods[mod_sel] = ~cur_mods[mod_sel];
        end
        if ($urandom_range(3) == 0) cur_mods ^= 8'($urandom);
        for (int s = 0; s < 6; s++) begin
          r = $urandom_range(99);
          if (r < 15) cur_keys[s] = 8'h00;
          else if (r < 35) cur_keys[s] = pick_usage();
          else if (r < 40) begin
            slot_sel = 3'($urandom_range(5));
            cur_keys[s] = cur_keys[slot_sel];
          end
        end
      end
      send_report(cur_mods, cur_keys);
    end
    drain_events();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_report(8'h00, 48'h00_00_00_00_00_00);
    send_report(8'h77, 48'h00_00_00_00_00_00);
    send_report(8'h88, 48'h00_00_00_00_00_00);
    send_report(8'h00, 48'h00_00_00_00_00_00);
    send_report(8'hFF, 48'h28_27_26_1E_1D_04);
    send_report(8'h00, 48'h50_4F_2C_2B_2A_29);
    send_report(8'h00, 48'hE6_E5_E4_E2_E1_E0);
    send_report(8'h00, 48'h00_00_E6_E5_52_51);
    send_report(8'h00, 48'hFF_E7_E3_53_2D_03);
    send_report(8'h00, 48'hFF_FF_FF_FF_FF_FF);
    send_report(8'h00, 48'h00_00_00_05_05_05);
    send_report(8'h00, 48'h00_00_00_05_05_05);
    send_report(8'h00, 48'h00_00_00_06_05_00);
    send_report(8'h00, 48'h05_00_00_00_00_06);
    send_report(8'h00, 48'h00_00_00_00_00_00);
    send_report(8'h00, 48'h00_00_00_00_07_07);
    send_report(8'h00, 48'h00_00_00_00_00_00);
    send_report(8'h12, 48'h00_00_00_00_00_01);
    send_report(8'h00, 48'h00_00_00_00_00_00);
    send_report(8'h00, 48'h00_00_00_00_DF_4E);
    send_report(8'h00, 48'h00_00_00_00_00_00);
    drain_events();

    run_phase(0, 0);
    run_phase(75, 0);
    run_phase(0, 75);
    run_phase(37, 37);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/hrkd_pkg.sv
rtl/hrkd_diff.sv
rtl/hrkd_drain.sv
rtl/hid_report_key_event_diff.sv
tb/key_event_checker.sv
tb/testbench.sv
